### hw/rtl/page_frame_allocator_fifo_evict_macros.svh
// Assertion helpers for the allocator datapath RTL.
`ifndef PAGE_FRAME_ALLOCATOR_FIFO_EVICT_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_FIFO_EVICT_MACROS_SVH

// Check a property on every edge outside reset.
`define PFA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define PFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/pfa_pkg.sv
package pfa_pkg;

   localparam int FRAMES     = 64;
   localparam int PAGE_BYTES = 1024;
   localparam int MAX_PROCS  = 16;

   localparam int FRAME_W    = $clog2(FRAMES);
   localparam int CNT_W      = FRAME_W + 1;
   localparam int SLOT_W     = $clog2(MAX_PROCS);
   localparam int AGE_W      = SLOT_W;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int SIZE_W     = 17;
   localparam int SUM_W      = SIZE_W + 1;
   localparam int PAGES_W    = SUM_W - PAGE_SHIFT;
   localparam int PID_W      = 16;
   localparam int EVICT_W    = 5;
   localparam int RAM_DEPTH  = MAX_PROCS * FRAMES;
   localparam int RAM_AW     = SLOT_W + FRAME_W;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [2:0] ST_MAPPED   = 3'd0;
   localparam logic [2:0] ST_FAILED   = 3'd1;
   localparam logic [2:0] ST_RELEASED = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_ZERO     = 3'd4;

   typedef struct packed {
      logic              opcode;
      logic [PID_W-1:0]  process_id;
      logic [SIZE_W-1:0] size_bytes;
      logic              evict_mode;
   } pfa_req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [PID_W-1:0]   process_id_res;
      logic [5:0]         page_index;
      logic [5:0]         frame;
      logic [EVICT_W-1:0] evicted_count;
      logic               last;
   } pfa_rsp_type;

   typedef struct packed {
      logic       load;
      logic       scan_start;
      logic       scan_step;
      logic       rm_start;
      logic       rm_step;
      logic       rm_finish;
      logic       insert;
      logic       grant;
      logic       reply;
      logic [2:0] code;
   } pfa_cmd_type;

   typedef struct packed {
      logic op;
      logic no_evict;
      logic scan_last;
      logic pages_over;
      logic zero_pages;
      logic have_slot;
      logic vic_any;
      logic is_short;
      logic rm_done;
      logic grant_last;
      logic out_free;
   } pfa_stat_type;

endpackage

### hw/rtl/pfa_ram.sv
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/pfa_ctrl.sv
module pfa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pfa_pkg::pfa_stat_type st,
   output pfa_pkg::pfa_cmd_type  cmd
);
   import pfa_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_CHK   = 4'd2;
   localparam logic [3:0] S_RM    = 4'd3;
   localparam logic [3:0] S_RMFIN = 4'd4;
   localparam logic [3:0] S_INS   = 4'd5;
   localparam logic [3:0] S_GRANT = 4'd6;
   localparam logic [3:0] S_REPLY = 4'd7;

   logic [3:0] state_ff, state_in;
   logic [2:0] code_ff, code_in;

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (st.scan_last) state_in = S_CHK;
         end
         S_CHK: begin
            if (st.op == OP_RELEASE) begin
               if (!st.vic_any) begin
                  code_in  = ST_NOTFOUND;
                  state_in = S_REPLY;
               end else begin
                  cmd.rm_start = 1'b1;
                  state_in     = S_RM;
               end
            end else if (st.pages_over || !st.have_slot || (st.is_short && st.no_evict)) begin
               code_in  = ST_FAILED;
               state_in = S_REPLY;
            end else if (st.is_short) begin
               cmd.rm_start = 1'b1;
               state_in     = S_RM;
            end else begin
               state_in = S_INS;
            end
         end
         S_RM: begin
            cmd.rm_step = 1'b1;
            if (st.rm_done) state_in = S_RMFIN;
         end
         S_RMFIN: begin
            cmd.rm_finish = 1'b1;
            if (st.op == OP_RELEASE) begin
               code_in  = ST_RELEASED;
               state_in = S_REPLY;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_INS: begin
            cmd.insert = 1'b1;
            if (st.zero_pages) begin
               code_in  = ST_ZERO;
               state_in = S_REPLY;
            end else begin
               state_in = S_GRANT;
            end
         end
         S_GRANT: begin
            cmd.grant = 1'b1;
            if (st.grant_last) state_in = S_IDLE;
         end
         S_REPLY: begin
            cmd.reply = 1'b1;
            cmd.code  = code_ff;
            if (st.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end
endmodule

### hw/rtl/pfa_dp.sv
`include "page_frame_allocator_fifo_evict_macros.svh"

module pfa_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  pfa_pkg::pfa_req_type  req_data,
   input  pfa_pkg::pfa_cmd_type  cmd,
   output pfa_pkg::pfa_stat_type st,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output pfa_pkg::pfa_rsp_type  rsp_data
);
   import pfa_pkg::*;

   pfa_req_type        req_ff, req_in;
   logic [PAGES_W-1:0] pages_ff, pages_in;
   logic [EVICT_W-1:0] evict_ff, evict_in;

   logic [MAX_PROCS-1:0] slot_valid_ff, slot_valid_in;
   logic [PID_W-1:0]     slot_pid_ff [MAX_PROCS];
   logic [PID_W-1:0]     slot_pid_in [MAX_PROCS];
   logic [CNT_W-1:0]     slot_cnt_ff [MAX_PROCS];
   logic [CNT_W-1:0]     slot_cnt_in [MAX_PROCS];
   logic [AGE_W-1:0]     slot_age_ff [MAX_PROCS];
   logic [AGE_W-1:0]     slot_age_in [MAX_PROCS];

   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              have_ff, have_in;
   logic [SLOT_W-1:0] free_slot_ff, free_slot_in;
   logic              vic_any_ff, vic_any_in;
   logic [SLOT_W-1:0] vic_idx_ff, vic_idx_in;
   logic [AGE_W-1:0]  vic_age_ff, vic_age_in;
   logic [CNT_W-1:0]  vic_cnt_ff, vic_cnt_in;

   logic [FRAMES-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]   free_ff, free_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [FRAME_W-1:0] f_ff, f_in;
   logic               pend_ff, pend_in;

   logic        rsp_valid_ff, rsp_valid_in;
   pfa_rsp_type rsp_ff, rsp_in;

   logic               out_free;
   logic               do_grant;
   logic               grant_last;
   logic               take;
   logic [SUM_W-1:0]   size_sum;
   logic               ram_wr_en, ram_rd_en;
   logic [RAM_AW-1:0]  ram_wr_addr, ram_rd_addr;
   logic [FRAME_W-1:0] ram_rd_data;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign size_sum    = SUM_W'(req_data.size_bytes) + SUM_W'(PAGE_BYTES - 1);
   assign do_grant    = cmd.grant && !used_ff[f_ff] && out_free;
   assign grant_last  = do_grant && ((PAGES_W'(k_ff) + PAGES_W'(1)) == pages_ff);
   assign ram_wr_addr = {free_slot_ff, k_ff[FRAME_W-1:0]};
   assign ram_rd_addr = {vic_idx_ff, k_ff[FRAME_W-1:0]};
   assign ram_wr_en   = do_grant;

   pfa_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (RAM_DEPTH)
   ) u_frames (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (f_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      req_in        = req_ff;
      pages_in      = pages_ff;
      evict_in      = evict_ff;
      slot_valid_in = slot_valid_ff;
      slot_pid_in   = slot_pid_ff;
      slot_cnt_in   = slot_cnt_ff;
      slot_age_in   = slot_age_ff;
      idx_in        = idx_ff;
      have_in       = have_ff;
      free_slot_in  = free_slot_ff;
      vic_any_in    = vic_any_ff;
      vic_idx_in    = vic_idx_ff;
      vic_age_in    = vic_age_ff;
      vic_cnt_in    = vic_cnt_ff;
      used_in       = used_ff;
      free_in       = free_ff;
      k_in          = k_ff;
      f_in          = f_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ram_rd_en     = 1'b0;
      take          = 1'b0;

      if (cmd.load) begin
         req_in   = req_data;
         pages_in = size_sum[PAGE_SHIFT +: PAGES_W];
         evict_in = '0;
         have_in  = 1'b0;
      end
      if (cmd.load || cmd.scan_start) begin
         idx_in     = '0;
         vic_any_in = 1'b0;
      end

      // one table entry per cycle
      if (cmd.scan_step) begin
         idx_in = idx_ff + SLOT_W'(1);
         if (req_ff.opcode == OP_RELEASE) begin
            take = slot_valid_ff[idx_ff] && (slot_pid_ff[idx_ff] == req_ff.process_id)
                   && (!vic_any_ff || (slot_age_ff[idx_ff] < vic_age_ff));
         end else begin
            if (!slot_valid_ff[idx_ff] && !have_ff) begin
               have_in      = 1'b1;
               free_slot_in = idx_ff;
            end
            take = slot_valid_ff[idx_ff]
                   && (!vic_any_ff || (slot_age_ff[idx_ff] > vic_age_ff));
         end
         if (take) begin
            vic_any_in = 1'b1;
            vic_idx_in = idx_ff;
            vic_age_in = slot_age_ff[idx_ff];
            vic_cnt_in = slot_cnt_ff[idx_ff];
         end
      end

      if (cmd.rm_start) begin
         k_in    = '0;
         pend_in = 1'b0;
      end

      // issue one page read per cycle, free the frame in the cycle after its read
      if (cmd.rm_step) begin
         if (k_ff < vic_cnt_ff) begin
            ram_rd_en = 1'b1;
            k_in      = k_ff + CNT_W'(1);
            pend_in   = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff && used_ff[ram_rd_data]) begin
            used_in[ram_rd_data] = 1'b0;
            free_in              = free_ff + CNT_W'(1);
         end
      end

      if (cmd.rm_finish) begin
         for (int i = 0; i < MAX_PROCS; i++) begin
            if (slot_valid_ff[i] && (slot_age_ff[i] > vic_age_ff)) begin
               slot_age_in[i] = slot_age_ff[i] - AGE_W'(1);
            end
         end
         slot_valid_in[vic_idx_ff] = 1'b0;
         if (req_ff.opcode == OP_ALLOC) evict_in = evict_ff + EVICT_W'(1);
      end

      if (cmd.insert) begin
         for (int i = 0; i < MAX_PROCS; i++) begin
            if (slot_valid_ff[i]) slot_age_in[i] = slot_age_ff[i] + AGE_W'(1);
         end
         slot_valid_in[free_slot_ff] = 1'b1;
         slot_pid_in[free_slot_ff]   = req_ff.process_id;
         slot_cnt_in[free_slot_ff]   = pages_ff[CNT_W-1:0];
         slot_age_in[free_slot_ff]   = '0;
         k_in                        = '0;
         f_in                        = '0;
      end

      // walk frames upward, grant each free one while the output can take it
      if (cmd.grant) begin
         if (used_ff[f_ff]) begin
            f_in = f_ff + FRAME_W'(1);
         end else if (out_free) begin
            used_in[f_ff]        = 1'b1;
            free_in              = free_ff - CNT_W'(1);
            f_in                 = f_ff + FRAME_W'(1);
            k_in                 = k_ff + CNT_W'(1);
            rsp_valid_in         = 1'b1;
            rsp_in.status        = ST_MAPPED;
            rsp_in.process_id_res = req_ff.process_id;
            rsp_in.page_index    = k_ff[5:0];
            rsp_in.frame         = 6'(f_ff);
            rsp_in.evicted_count = evict_ff;
            rsp_in.last          = grant_last;
         end
      end

      if (cmd.reply && out_free) begin
         rsp_valid_in          = 1'b1;
         rsp_in.status         = cmd.code;
         rsp_in.process_id_res = req_ff.process_id;
         rsp_in.page_index     = '0;
         rsp_in.frame          = '0;
         rsp_in.evicted_count  = evict_ff;
         rsp_in.last           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         used_ff       <= '0;
         free_ff       <= CNT_W'(FRAMES);
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         used_ff       <= used_in;
         free_ff       <= free_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      pages_ff     <= pages_in;
      evict_ff     <= evict_in;
      slot_pid_ff  <= slot_pid_in;
      slot_cnt_ff  <= slot_cnt_in;
      slot_age_ff  <= slot_age_in;
      idx_ff       <= idx_in;
      have_ff      <= have_in;
      free_slot_ff <= free_slot_in;
      vic_any_ff   <= vic_any_in;
      vic_idx_ff   <= vic_idx_in;
      vic_age_ff   <= vic_age_in;
      vic_cnt_ff   <= vic_cnt_in;
      k_ff         <= k_in;
      f_ff         <= f_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      st            = '0;
      st.op         = req_ff.opcode;
      st.no_evict   = req_ff.evict_mode;
      st.scan_last  = (idx_ff == SLOT_W'(MAX_PROCS - 1));
      st.pages_over = (pages_ff > PAGES_W'(FRAMES));
      st.zero_pages = (pages_ff == '0);
      st.have_slot  = have_ff;
      st.vic_any    = vic_any_ff;
      st.is_short   = (PAGES_W'(free_ff) < pages_ff);
      st.rm_done    = (k_ff == vic_cnt_ff) && !pend_ff;
      st.grant_last = grant_last;
      st.out_free   = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PFA_ASSERT(a_free_matches_map, clock, reset, ($countones(used_ff) + int'(free_ff)) == FRAMES, "free count disagrees with frame map")
   `PFA_ASSERT(a_insert_free_slot, clock, reset, cmd.insert |-> (have_ff && !slot_valid_ff[free_slot_ff]), "insert into occupied slot")
   `PFA_ASSERT(a_grant_in_range, clock, reset, do_grant |-> (PAGES_W'(k_ff) < pages_ff), "granted more pages than requested")
   `PFA_ASSERT(a_release_used_frame, clock, reset, (cmd.rm_step && pend_ff) |-> used_ff[ram_rd_data], "releasing a frame not in use")
   `PFA_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid_ff && (free_ff == CNT_W'(FRAMES))), "reset left state behind")
endmodule

### hw/rtl/page_frame_allocator_fifo_evict.sv
// Channel   Ports                          Direction  Transaction
// request   req_valid/req_ready/req_data   in         allocate or release one process
// response  rsp_valid/rsp_ready/rsp_data   out        one mapping or one status word
//
// One request is worked at a time. A request first walks the 16-entry process
// table, one entry per cycle, then: a release frees the newest match at one
// frame per cycle through the page-frame RAM read port; an allocate that is
// short evicts the oldest process the same way and rescans the table per
// victim; grants then walk the 64 frames upward, one per cycle while the
// response channel can take a mapping.
// Reset is synchronous and clears the frame map, free count, table valid bits
// and the output valid bit at once; no clearing pass is needed.
// A stalled response holds the frame walk and the status reply; a new request
// is accepted while the last response of the previous one still waits.
module page_frame_allocator_fifo_evict (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pfa_pkg::pfa_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pfa_pkg::pfa_rsp_type rsp_data
);
   import pfa_pkg::*;

   // command and status between sequencer and datapath
   pfa_cmd_type  cmd;
   pfa_stat_type st;

   // sequence scans, evictions, inserts and grants
   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // hold the table, frame map, page-frame RAM and output register
   pfa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .st        (st),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule
